### hw/rtl/sbp_pkg.sv
// Shared types, codes and constants of the spanning-tree BPDU byte parser.
package sbp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COUNT_W  = 6;
    localparam int unsigned ID_W     = 64;
    localparam int unsigned COST_W   = 32;
    localparam int unsigned PORT_W   = 16;
    localparam int unsigned TIMERS   = 4;
    localparam int unsigned RESULT_W = 234;
    localparam int unsigned M_DATA_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX       = 6'd63;
    localparam logic [COUNT_W-1:0] BPDU_MIN_CONFIG = 6'd35;
    localparam logic [COUNT_W-1:0] FRAME_MIN       = 6'd3;
    localparam logic [COUNT_W-1:0] BPDU_MIN_TCN    = 6'd4;
    localparam logic [3:0]         BASE_NONE       = 4'd0;
    localparam logic [3:0]         BASE_LLC        = 4'd3;
    localparam logic [3:0]         BASE_SNAP       = 4'd8;
    localparam logic [15:0]        SAP_STP         = 16'h4242;
    localparam logic [15:0]        SAP_SNAP        = 16'hAAAA;
    localparam logic [7:0]         TYPE_TCN        = 8'h80;

    typedef enum logic [1:0] {
        ST_NOT_STP   = 2'd0,
        ST_TRUNCATED = 2'd1,
        ST_TCN       = 2'd2,
        ST_CONFIG    = 2'd3
    } sbp_status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } sbp_beat_t;

    typedef struct packed {
        sbp_status_t       status;
        logic [BYTE_W-1:0] version;
        logic [BYTE_W-1:0] bpdu_kind;
        logic [BYTE_W-1:0] flag_bits;
        logic [ID_W-1:0]   root_bridge_id;
        logic [COST_W-1:0] root_cost;
        logic [ID_W-1:0]   sender_bridge_id;
        logic [PORT_W-1:0] port_ident;
        logic [BYTE_W-1:0] message_age_s;
        logic [BYTE_W-1:0] max_age_s;
        logic [BYTE_W-1:0] hello_s;
        logic [BYTE_W-1:0] forward_delay_s;
    } sbp_result_t;

    // Expected SNAP header bytes 2 through 7: 03 00 00 0C 01 0B.
    function automatic logic [BYTE_W-1:0] snap_hdr_byte(input logic [2:0] idx);
        logic [BYTE_W-1:0] val;
        case (idx)
            3'd0:    val = 8'h03;
            3'd1:    val = 8'h00;
            3'd2:    val = 8'h00;
            3'd3:    val = 8'h0C;
            3'd4:    val = 8'h01;
            3'd5:    val = 8'h0B;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

### hw/rtl/sbp_in_stage.sv
// Input register of the parser: holds one byte item and its last flag.
module sbp_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  sbp_pkg::sbp_beat_t s_beat,
    input  logic              advance,
    output logic              beat_valid,
    output sbp_pkg::sbp_beat_t beat
);
    import sbp_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    sbp_beat_t beat_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = (s_tvalid && s_tready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            beat_reg <= s_beat;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

### hw/rtl/sbp_capture.sv
// Per-frame field capture and classification of one BPDU byte at a time.
module sbp_capture (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_en,
    input  sbp_pkg::sbp_beat_t  beat,
    output sbp_pkg::sbp_result_t result
);
    import sbp_pkg::*;

    localparam logic [COUNT_W-1:0] OFF_TIMER0 = 6'd27;

    logic [COUNT_W-1:0] cnt_reg,     cnt_next;
    logic [15:0]        first_reg,   first_next;
    logic               snap_reg,    snap_next;
    logic               proto_reg,   proto_next;
    logic [BYTE_W-1:0]  version_reg, version_next;
    logic [BYTE_W-1:0]  kind_reg,    kind_next;
    logic [BYTE_W-1:0]  flags_reg,   flags_next;
    logic [ID_W-1:0]    root_reg,    root_next;
    logic [COST_W-1:0]  cost_reg,    cost_next;
    logic [ID_W-1:0]    bridge_reg,  bridge_next;
    logic [PORT_W-1:0]  port_reg,    port_next;
    logic [BYTE_W-1:0]  timer_reg  [TIMERS];
    logic [BYTE_W-1:0]  timer_next [TIMERS];

    logic [BYTE_W-1:0]  b;
    logic [3:0]         base;
    logic [3:0]         base_end;
    logic [COUNT_W-1:0] off;
    logic [COUNT_W-1:0] timer_off;
    logic [COUNT_W-1:0] hdr_idx;
    logic [COUNT_W-1:0] blen;
    sbp_status_t        status;
    logic               full;

    assign b = beat.data_byte;

    // Field update for the byte at position cnt_reg.
    always_comb
    begin
        cnt_next     = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 6'd1;
        first_next   = first_reg;
        snap_next    = snap_reg;
        proto_next   = proto_reg;
        version_next = version_reg;
        kind_next    = kind_reg;
        flags_next   = flags_reg;
        root_next    = root_reg;
        cost_next    = cost_reg;
        bridge_next  = bridge_reg;
        port_next    = port_reg;
        for (int i = 0; i < TIMERS; i++)
        begin
            timer_next[i] = timer_reg[i];
        end

        if (first_reg == SAP_STP)
        begin
            base = BASE_LLC;
        end
        else if (first_reg == SAP_SNAP)
        begin
            base = BASE_SNAP;
        end
        else
        begin
            base = BASE_NONE;
        end

        off       = cnt_reg - {2'b00, base};
        timer_off = off - OFF_TIMER0;
        hdr_idx   = cnt_reg - 6'd2;

        if (cnt_reg == 6'd0)
        begin
            first_next = {b, 8'h00};
        end
        else if (cnt_reg == 6'd1)
        begin
            first_next = {first_reg[15:8], b};
        end
        else
        begin
            if (cnt_reg <= 6'd7 && snap_hdr_byte(hdr_idx[2:0]) != b)
            begin
                snap_next = 1'b0;
            end
            if (base != BASE_NONE && cnt_reg >= {2'b00, base})
            begin
                case (off) inside
                    [6'd0:6'd1]:   proto_next   = proto_reg && (b == 8'h00);
                    6'd2:          version_next = b;
                    6'd3:          kind_next    = b;
                    6'd4:          flags_next   = b;
                    [6'd5:6'd12]:  root_next    = {root_reg[ID_W-9:0], b};
                    [6'd13:6'd16]: cost_next    = {cost_reg[COST_W-9:0], b};
                    [6'd17:6'd24]: bridge_next  = {bridge_reg[ID_W-9:0], b};
                    [6'd25:6'd26]: port_next    = {port_reg[PORT_W-9:0], b};
                    6'd27, 6'd29, 6'd31, 6'd33:
                        timer_next[timer_off[2:1]] = b;
                    default: ;
                endcase
            end
        end
    end

    // Classification as of the byte just taken, used when it closes the frame.
    always_comb
    begin
        if (first_next == SAP_STP)
        begin
            base_end = BASE_LLC;
        end
        else if (first_next == SAP_SNAP)
        begin
            base_end = BASE_SNAP;
        end
        else
        begin
            base_end = BASE_NONE;
        end
        blen = cnt_next - {2'b00, base_end};

        if (cnt_next < FRAME_MIN)
        begin
            status = ST_TRUNCATED;
        end
        else if (base_end == BASE_NONE ||
                 (base_end == BASE_SNAP && (cnt_next < 6'd8 || !snap_next)))
        begin
            status = ST_NOT_STP;
        end
        else if (blen < BPDU_MIN_TCN)
        begin
            status = ST_TRUNCATED;
        end
        else if (!proto_next)
        begin
            status = ST_NOT_STP;
        end
        else if (kind_next == TYPE_TCN)
        begin
            status = ST_TCN;
        end
        else if (blen < BPDU_MIN_CONFIG)
        begin
            status = ST_TRUNCATED;
        end
        else
        begin
            status = ST_CONFIG;
        end

        full = (status == ST_CONFIG);
        result.status           = status;
        result.version          = (status == ST_TCN || full) ? version_next : '0;
        result.bpdu_kind        = (status == ST_TCN || full) ? kind_next : '0;
        result.flag_bits        = full ? flags_next  : '0;
        result.root_bridge_id   = full ? root_next   : '0;
        result.root_cost        = full ? cost_next   : '0;
        result.sender_bridge_id = full ? bridge_next : '0;
        result.port_ident       = full ? port_next   : '0;
        result.message_age_s    = full ? timer_next[0] : '0;
        result.max_age_s        = full ? timer_next[1] : '0;
        result.hello_s          = full ? timer_next[2] : '0;
        result.forward_delay_s  = full ? timer_next[3] : '0;
    end

    // The last byte of a frame returns every field to its idle value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            first_reg   <= '0;
            snap_reg    <= 1'b1;
            proto_reg   <= 1'b1;
            version_reg <= '0;
            kind_reg    <= '0;
            flags_reg   <= '0;
            root_reg    <= '0;
            cost_reg    <= '0;
            bridge_reg  <= '0;
            port_reg    <= '0;
            for (int i = 0; i < TIMERS; i++)
            begin
                timer_reg[i] <= '0;
            end
        end
        else if (byte_en && beat.last)
        begin
            cnt_reg     <= '0;
            first_reg   <= '0;
            snap_reg    <= 1'b1;
            proto_reg   <= 1'b1;
            version_reg <= '0;
            kind_reg    <= '0;
            flags_reg   <= '0;
            root_reg    <= '0;
            cost_reg    <= '0;
            bridge_reg  <= '0;
            port_reg    <= '0;
            for (int i = 0; i < TIMERS; i++)
            begin
                timer_reg[i] <= '0;
            end
        end
        else if (byte_en)
        begin
            cnt_reg     <= cnt_next;
            first_reg   <= first_next;
            snap_reg    <= snap_next;
            proto_reg   <= proto_next;
            version_reg <= version_next;
            kind_reg    <= kind_next;
            flags_reg   <= flags_next;
            root_reg    <= root_next;
            cost_reg    <= cost_next;
            bridge_reg  <= bridge_next;
            port_reg    <= port_next;
            for (int i = 0; i < TIMERS; i++)
            begin
                timer_reg[i] <= timer_next[i];
            end
        end
    end

    a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
        byte_en && beat.last |=> cnt_reg == '0 && snap_reg && proto_reg && first_reg == '0)
        else $error("frame state not cleared after last byte");

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        byte_en && !beat.last && cnt_reg != COUNT_MAX |=> cnt_reg == $past(cnt_reg) + 6'd1)
        else $error("byte counter did not advance");

    a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_en |=> $stable(cnt_reg))
        else $error("byte counter moved without a byte");

endmodule

### hw/rtl/sbp_out_stage.sv
// Result register of the parser: holds one result item until it is taken.
module sbp_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  sbp_pkg::sbp_result_t result_in,
    output logic                 free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output sbp_pkg::sbp_result_t result_out
);
    import sbp_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    sbp_result_t result_reg;

    assign free       = !valid_reg || m_tready;
    assign valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign m_tvalid   = valid_reg;
    assign result_out = result_reg;

endmodule

### hw/rtl/stp_bpdu_byte_parser.sv
// Top level of the spanning-tree BPDU byte parser.
//
// The slave stream carries the LLC payload of one frame, one byte item per
// transfer starting at DSAP, with tlast on the final byte. The master stream
// carries one result item per frame, sent after the tlast byte: status, the
// BPDU header fields, identifiers, cost, port and the four timers in seconds.
// Frames with plain LLC (42 42) or SNAP with the PVST+ header are decoded;
// anything else reports not-STP, and short frames report truncated.
// A byte item is taken into an input register, then updates the per-frame
// field registers; a middle byte always moves on, while a tlast byte waits
// there until the result register is free, then also loads that register.
// One byte item is accepted every cycle while tready is high; tready drops
// only when a tlast byte waits in the input register while an untaken result
// sits in the result register; a stalled receiver therefore lets at most one
// further frame in before tready drops. Reset clears the valid flags and all
// per-frame fields; the first byte after reset is the DSAP of a new frame.
module stp_bpdu_byte_parser (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,   // last
    output logic         m_tvalid,
    input  logic         m_tready,
    // [1:0] status, [9:2] version, [17:10] bpdu_kind, [25:18] flag_bits,
    // [89:26] root_bridge_id, [121:90] root_cost, [185:122] sender_bridge_id,
    // [201:186] port_ident, [209:202] message_age_s, [217:210] max_age_s,
    // [225:218] hello_s, [233:226] forward_delay_s, [239:234] zero
    output logic [sbp_pkg::M_DATA_W-1:0] m_tdata
);
    import sbp_pkg::*;

    sbp_beat_t   s_beat;
    sbp_beat_t   beat;
    logic        beat_valid;
    logic        advance;
    logic        load;
    logic        out_free;
    sbp_result_t result;
    sbp_result_t result_out;

    assign s_beat.data_byte = s_tdata;
    assign s_beat.last      = s_tlast;

    // A middle byte always moves on; a closing byte needs the result register.
    assign advance = beat_valid && (!beat.last || out_free);
    assign load    = advance && beat.last;

    sbp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_beat     (s_beat),
        .advance    (advance),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    sbp_capture u_capture (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (advance),
        .beat    (beat),
        .result  (result)
    );

    sbp_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .result_in  (result),
        .free       (out_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .result_out (result_out)
    );

    assign m_tdata = {
        {(M_DATA_W - RESULT_W){1'b0}},
        result_out.forward_delay_s,
        result_out.hello_s,
        result_out.max_age_s,
        result_out.message_age_s,
        result_out.port_ident,
        result_out.sender_bridge_id,
        result_out.root_cost,
        result_out.root_bridge_id,
        result_out.flag_bits,
        result_out.bpdu_kind,
        result_out.version,
        result_out.status
    };

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> beat_valid && beat.last && m_tvalid && !m_tready)
        else $error("input stalled without a blocked closing byte");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !m_tvalid || m_tready)
        else $error("result overwritten before it was taken");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (result_out.status == ST_NOT_STP || result_out.status == ST_TRUNCATED)
        |-> result_out.version == '0 && result_out.bpdu_kind == '0 &&
            result_out.root_bridge_id == '0)
        else $error("fields not zero on a rejected frame");

endmodule
